>>> sv/lzssrd_pkg.sv
package lzssrd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LIMIT_W    = 24;
    localparam int FLAG_W     = 9;
    localparam int LEN_W      = 5;
    localparam int START_BACK = 18;

    localparam logic [FLAG_W-1:0] FLAG_MARK = 9'h100;
    localparam logic [FLAG_W-1:0] FLAG_NONE = 9'h001;
    localparam logic [LEN_W-1:0]  LEN_BIAS  = 5'd3;
    localparam logic [LEN_W-1:0]  LEN_ONE   = 5'd1;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic take;
        logic read;
        logic put;
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   lit_flag;
        logic   final_byte;
        logic   put_stall;
    } status_t;

endpackage

>>> sv/lzssrd_in_if.sv
interface lzssrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

>>> sv/lzssrd_out_if.sv
interface lzssrd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> sv/lzssrd_cfg_if.sv
interface lzssrd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/lzssrd_ctrl.sv
module lzssrd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lzssrd_pkg::status_t status,
    output lzssrd_pkg::cmd_t    cmd
);
    import lzssrd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.phase == PH_TOKEN && status.lit_flag)
                    begin
                        state_next = ST_PUT;
                    end
                    else if (status.phase == PH_HIGH)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (!status.put_stall)
                begin
                    cmd.put    = 1'b1;
                    state_next = status.final_byte ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lzssrd_dp.sv
module lzssrd_dp #(
    parameter int RING_DEPTH = 4096,
    parameter int COUNT_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lzssrd_pkg::cmd_t                    cmd,
    output lzssrd_pkg::status_t                 status,
    input  logic [lzssrd_pkg::BYTE_W-1:0]       in_byte,
    input  logic                                in_last,
    input  logic                                cfg_valid,
    input  logic [lzssrd_pkg::LIMIT_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lzssrd_pkg::BYTE_W-1:0]       out_byte,
    output logic                                out_last
);
    import lzssrd_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [AW-1:0] RING_START = AW'(RING_DEPTH - START_BACK);
    localparam logic [AW:0]   FILL_FULL  = (AW+1)'(RING_DEPTH);

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;

    phase_t                phase_reg, phase_next;
    logic [FLAG_W-1:0]     flag_reg, flag_next;
    logic [BYTE_W-1:0]     low_reg, low_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [AW:0]           fill_reg, fill_next;
    logic [COUNT_BITS-1:0] emitted_reg, emitted_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [AW-1:0]         src_reg;
    logic [LEN_W-1:0]      remain_reg;
    logic                  last_item_reg;
    logic                  copy_reg;
    logic                  hit_reg;
    logic [BYTE_W-1:0]     lit_reg;
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_last_reg;

    logic [BYTE_W-1:0]     put_data;
    logic [COUNT_BITS-1:0] emitted_inc;
    logic                  emit_ok;
    logic                  emit_ok_after;
    logic                  final_byte;
    logic                  clear;
    logic [AW-1:0]         src_off;
    logic [FLAG_W-1:0]     flag_shifted;

    assign emitted_inc   = emitted_reg + COUNT_BITS'(1);
    assign emit_ok       = (CW'(emitted_reg) < CW'(limit_reg)) && (emitted_reg != '1);
    assign emit_ok_after = (CW'(emitted_inc) < CW'(limit_reg)) && (emitted_inc != '1);
    assign final_byte    = (remain_reg == LEN_ONE);
    assign put_data      = copy_reg ? (hit_reg ? mem_q_reg : '0) : lit_reg;
    assign src_off       = src_reg - RING_START;
    assign flag_shifted  = flag_reg >> 1;

    assign status.phase      = phase_reg;
    assign status.lit_flag   = flag_reg[0];
    assign status.final_byte = final_byte;
    assign status.put_stall  = emit_ok && out_valid_reg && !out_ready;

    always_comb
    begin
        phase_next   = phase_reg;
        flag_next    = flag_reg;
        low_next     = low_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        emitted_next = emitted_reg;
        clear        = 1'b0;
        if (cmd.take)
        begin
            case (phase_reg)
                PH_FLAG:
                begin
                    flag_next  = FLAG_W'(in_byte) | FLAG_MARK;
                    phase_next = PH_TOKEN;
                    clear      = in_last;
                end
                PH_TOKEN:
                begin
                    if (!flag_reg[0])
                    begin
                        low_next   = in_byte;
                        phase_next = PH_HIGH;
                        clear      = in_last;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.put)
        begin
            wp_next = wp_reg + AW'(1);
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + (AW+1)'(1);
            end
            if (emit_ok)
            begin
                emitted_next = emitted_inc;
            end
            if (final_byte)
            begin
                phase_next = (flag_shifted <= FLAG_NONE) ? PH_FLAG : PH_TOKEN;
                flag_next  = (flag_shifted == '0) ? FLAG_NONE : flag_shifted;
                clear      = last_item_reg;
            end
        end
        if (clear)
        begin
            phase_next   = PH_FLAG;
            flag_next    = FLAG_NONE;
            low_next     = '0;
            wp_next      = RING_START;
            fill_next    = '0;
            emitted_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAG;
            flag_reg      <= FLAG_NONE;
            low_reg       <= '0;
            wp_reg        <= RING_START;
            fill_reg      <= '0;
            emitted_reg   <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            flag_reg    <= flag_next;
            low_reg     <= low_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            emitted_reg <= emitted_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.put && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            last_item_reg <= in_last;
            lit_reg       <= in_byte;
            if (phase_reg == PH_HIGH)
            begin
                copy_reg   <= 1'b1;
                src_reg    <= AW'({in_byte[7:4], low_reg});
                remain_reg <= LEN_W'(in_byte[3:0]) + LEN_BIAS;
            end
            else
            begin
                copy_reg   <= 1'b0;
                remain_reg <= LEN_ONE;
            end
        end
        if (cmd.read)
        begin
            src_reg <= src_reg + AW'(1);
            hit_reg <= ({1'b0, src_off} < fill_reg);
        end
        if (cmd.put)
        begin
            remain_reg <= remain_reg - LEN_ONE;
        end
        if (cmd.put && emit_ok)
        begin
            out_byte_reg <= put_data;
            out_last_reg <= final_byte || !emit_ok_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            ring_mem[wp_reg] <= put_data;
        end
        if (cmd.read)
        begin
            mem_q_reg <= ring_mem[src_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("ring fill count beyond depth");

    a_flag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg != '0)
        else $error("flag shift register empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put && emit_ok) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");

    a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (wp_reg == RING_START && fill_reg == '0 && emitted_reg == '0))
        else $error("stream end did not restart ring state");
`endif

endmodule

>>> sv/lzss_ring_decompressor_top.sv
// LZSS decompressor with a 4 KiB history ring.
// coded: compressed payload, one byte per beat; in_last marks the final byte
//   of a stream, after which ring, pointers and counters restart.
// plain: decompressed bytes, one per beat; out_last flags the last byte
//   produced by one compressed byte, or the last before output_limit is hit.
// cfg: writes output_limit; bytes past that count are decoded but dropped.
// Steps per compressed byte: a flag byte or first match byte is only taken;
//   a literal is taken, then put; a second match byte is taken, then each
//   of its 3 to 18 copied bytes is a read and a write on the single-port ring.
// A literal is put from ST_PUT once no stall holds, then offered on plain.
// The output register lets the next byte be taken while a result waits;
//   a stalled receiver holds the copy only when a byte must be emitted.
// Reset: limit 0, ring reads as zero, write pointer at depth - 18, no
//   clearing pass; every in_last beat restarts the same way but keeps the limit.
module lzss_ring_decompressor_top #(
    parameter int RING_DEPTH = 4096,
    parameter int COUNT_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    lzssrd_in_if.sink    coded,
    lzssrd_out_if.source plain,
    lzssrd_cfg_if.sink   cfg
);
    import lzssrd_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    lzssrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (coded.valid),
        .in_ready (coded.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lzssrd_dp #(
        .RING_DEPTH (RING_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (coded.in_byte),
        .in_last   (coded.in_last),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .out_valid (plain.valid),
        .out_ready (plain.ready),
        .out_byte  (plain.out_byte),
        .out_last  (plain.out_last)
    );

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lzssrd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int HIST_DEPTH     = 4096;
    localparam int ITEM_TARGET    = 380;
    localparam int RANDOM_PHASES  = 4;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 40;
    localparam int PREDICT        = -1;
    localparam logic [11:0] RING_START = 12'hFEE;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } plain_beat_t;

    typedef struct packed {
        logic        set_limit;
        logic [23:0] limit;
        logic [7:0]  value;
        logic        last;
        int          typed_n;
        logic [7:0]  typed_val;
    } coded_row_t;

    localparam int DIRECTED_ROWS = 25;

    coded_row_t directed [DIRECTED_ROWS] = '{
        '{1'b0, 24'd0,      8'h01, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hC3, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hEE, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hFF, 1'b1, 0,       8'h00},
        '{1'b1, 24'hFFFFFF, 8'h0F, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'h00, 1'b0, 1,       8'h00},
        '{1'b0, 24'd0,      8'hFF, 1'b0, 1,       8'hFF},
        '{1'b0, 24'd0,      8'h5A, 1'b0, 1,       8'h5A},
        '{1'b0, 24'd0,      8'hA5, 1'b0, 1,       8'hA5},
        '{1'b0, 24'd0,      8'hEE, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hF0, 1'b0, PREDICT, 8'h00},
        '{1'b0, 24'd0,      8'h00, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'h0F, 1'b0, PREDICT, 8'h00},
        '{1'b0, 24'd0,      8'hF8, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hF2, 1'b0, PREDICT, 8'h00},
        '{1'b0, 24'd0,      8'h12, 1'b1, 0,       8'h00},
        '{1'b0, 24'd0,      8'h00, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hEE, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hFF, 1'b1, 18,      8'h00},
        '{1'b1, 24'd5,      8'h01, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'h11, 1'b0, 1,       8'h11},
        '{1'b0, 24'd0,      8'hEE, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'hF3, 1'b0, 4,       8'h11},
        '{1'b0, 24'd0,      8'h00, 1'b0, 0,       8'h00},
        '{1'b0, 24'd0,      8'h00, 1'b1, 0,       8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;

    lzssrd_in_if  coded_ch ();
    lzssrd_out_if plain_ch ();
    lzssrd_cfg_if cfg_ch ();

    lzss_ring_decompressor_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coded (coded_ch),
        .plain (plain_ch),
        .cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    logic [7:0]  hist [HIST_DEPTH];
    logic [11:0] hist_wr;
    logic [8:0]  flag_bits;
    phase_t      coded_phase;
    logic [7:0]  match_lo;
    logic [23:0] emitted;
    logic [23:0] limit_now;

    logic [7:0]  decoded_now [$];
    plain_beat_t plain_expected [$];

    int  errors = 0;
    int  items_sent = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;

    function automatic void restart_stream();
        foreach (hist[i])
            hist[i] = 8'h00;
        hist_wr = RING_START;
        flag_bits = FLAG_NONE;
        coded_phase = PH_FLAG;
        match_lo = 8'h00;
        emitted = '0;
    endfunction

    function automatic void store_byte(input logic [7:0] value);
        hist[hist_wr] = value;
        hist_wr = hist_wr + 12'd1;
        if (emitted < limit_now && emitted != '1)
        begin
            decoded_now.push_back(value);
            emitted = emitted + 24'd1;
        end
    endfunction

    function automatic void close_token();
        flag_bits = flag_bits >> 1;
        coded_phase = (flag_bits <= FLAG_NONE) ? PH_FLAG : PH_TOKEN;
        if (flag_bits == '0)
            flag_bits = FLAG_NONE;
    endfunction

    function automatic void decode_byte(input logic [7:0] value, input logic last);
        logic [11:0] src;
        int count;
        decoded_now.delete();
        case (coded_phase)
            PH_FLAG:
            begin
                flag_bits = FLAG_MARK | {1'b0, value};
                coded_phase = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (flag_bits[0])
                begin
                    store_byte(value);
                    close_token();
                end
                else
                begin
                    match_lo = value;
                    coded_phase = PH_HIGH;
                end
            end
            default:
            begin
                src = {value[7:4], match_lo};
                count = int'(value[3:0]) + int'(LEN_BIAS);
                repeat (count)
                begin
                    store_byte(hist[src]);
                    src = src + 12'd1;
                end
                close_token();
            end
        endcase
        if (last)
            restart_stream();
    endfunction

    task automatic report_miss(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
        errors++;
    endtask

    task automatic send_beat(input logic [7:0] value, input logic last,
                             input int typed_n, input logic [7:0] typed_val);
        while (!steady && $urandom_range(99) < 30)
        begin
            coded_ch.valid <= 1'b0;
            @(posedge clk);
        end
        coded_ch.valid   <= 1'b1;
        coded_ch.in_byte <= value;
        coded_ch.in_last <= last;
        do
            @(posedge clk);
        while (!coded_ch.ready);
        decode_byte(value, last);
        if (typed_n != PREDICT)
        begin
            decoded_now.delete();
            repeat (typed_n)
                decoded_now.push_back(typed_val);
        end
        foreach (decoded_now[i])
            plain_expected.push_back('{value: decoded_now[i],
                                       last: (i == decoded_now.size() - 1)});
        items_sent++;
    endtask

    task automatic settle();
        coded_ch.valid <= 1'b0;
        while (plain_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_now = value;
    endtask

    task automatic send_stream(input bit broken);
        logic [7:0]  body [$];
        logic [7:0]  flag_byte;
        logic [11:0] src;
        logic [3:0]  len_code;
        int tokens;
        int made;
        int back;
        int cut;
        tokens = $urandom_range(24, 1);
        made = 0;
        while (tokens > 0)
        begin
            flag_byte = 8'($urandom);
            if (made == 0)
                flag_byte[0] = 1'b1;
            body.push_back(flag_byte);
            for (int i = 0; i < 8 && tokens > 0; i++)
            begin
                if (flag_byte[i])
                begin
                    body.push_back(8'($urandom));
                    made++;
                end
                else
                begin
                    len_code = 4'($urandom);
                    if ($urandom_range(4) == 0)
                        src = 12'($urandom);
                    else
                    begin
                        back = $urandom_range((made > 64) ? 64 : made, 1);
                        src = 12'(int'(RING_START) + made - back);
                    end
                    body.push_back(src[7:0]);
                    body.push_back({src[11:8], len_code});
                    made += int'(len_code) + int'(LEN_BIAS);
                end
                tokens--;
            end
        end
        cut = broken ? $urandom_range(body.size() - 1, 1) : body.size();
        for (int i = 0; i < cut; i++)
            send_beat(body[i], i == cut - 1, PREDICT, 8'h00);
    endtask

    initial
    begin : plain_sink
        plain_beat_t want;
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        plain_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && plain_ch.valid && plain_ch.ready)
            begin
                if (plain_expected.size() == 0)
                begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected beat, expected none, got %02h last %0b",
                                 $time, plain_ch.out_byte, plain_ch.out_last);
                    errors++;
                end
                else
                begin
                    want = plain_expected.pop_front();
                    if (plain_ch.out_byte !== want.value)
                        report_miss("out_byte", want.value, plain_ch.out_byte);
                    if (plain_ch.out_last !== want.last)
                        report_miss("out_last", {7'd0, want.last}, {7'd0, plain_ch.out_last});
                end
            end
            if (!held_once && hold_req)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                plain_ch.ready <= 1'b0;
            end
            else
                plain_ch.ready <= steady || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((coded_ch.valid && coded_ch.ready) || (plain_ch.valid && plain_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("lzss_ring_decompressor_top test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [23:0] next_limit;
        int phase_end;
        int phase_start;
        int pick;
        int burst;
        bit paused;
        paused = 1'b0;
        rst_n            <= 1'b0;
        coded_ch.valid   <= 1'b0;
        coded_ch.in_byte <= 8'h00;
        coded_ch.in_last <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;
        restart_stream();
        limit_now = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].set_limit)
            begin
                settle();
                write_limit(directed[i].limit);
            end
            send_beat(directed[i].value, directed[i].last, directed[i].typed_n,
                      directed[i].typed_val);
        end

        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            settle();
            case (phase_no)
                0: next_limit = 24'($urandom_range(400, 20));
                1: next_limit = 24'hFFFFFF;
                2: next_limit = 24'd1;
                default: next_limit = 24'($urandom);
            endcase
            write_limit(next_limit);
            steady = (phase_no == 1);
            phase_start = items_sent;
            phase_end = items_sent + (ITEM_TARGET - DIRECTED_ROWS) / RANDOM_PHASES;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(9);
                if (pick < 7)
                    send_stream(1'b0);
                else if (pick == 7)
                    send_stream(1'b1);
                else
                begin
                    burst = $urandom_range(12, 1);
                    for (int i = 0; i < burst; i++)
                        send_beat(8'($urandom), (i == burst - 1) || ($urandom_range(9) == 0),
                                  PREDICT, 8'h00);
                end
                if (steady && items_sent >= phase_start + HOLD_AFTER)
                    hold_req = 1'b1;
                if (phase_no == 0 && !paused)
                begin
                    paused = 1'b1;
                    settle();
                end
            end
            steady = 1'b0;
        end

        settle();
        if (errors == 0 && plain_expected.size() == 0)
            $display("lzss_ring_decompressor_top test passed");
        else
            $display("lzss_ring_decompressor_top test failed");
        $finish;
    end

endmodule
